[hdl/mhp_pkg.sv]
// shared types and codes for the max-heap block
// no dependencies
package mhp_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_FIND   = 2'd2;
    // spare code, handled as find
    localparam logic [1:0] FUNC_SPARE  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]   func;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]   status;
        logic         found;
        logic [6:0]   count;
        logic signed [31:0] top_value;
    } t_res;

endpackage

[hdl/mhp_ram.sv]
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module mhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/max_heap_insert_remove_find.sv]
// binary max-heap sequencer around one store ram
// depends on mhp_pkg and mhp_ram
//
// One request at a time: accepted when i_start is high and o_busy low, the
// result appears for one cycle on o_result with o_strobe, and must be taken
// then, as the receiver cannot stall the block. Every request on a non-empty
// store first scans it up to the match, since found is always reported.
// Insert then sifts up level by level. Remove shifts later entries left and
// repeats repair passes until one makes no swap; a pass visits every entry,
// reading its children and swapping where a child is larger. S_TOP and
// S_OUT then read the root and register the result. This pacing is set by
// the single read and single write port of the store ram. No clearing pass
// is needed after reset.
module max_heap_insert_remove_find
    import mhp_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_strobe,
    output t_res o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = AW + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_SCANC = 4'd2;
    localparam logic [3:0] S_DISP  = 4'd3;
    localparam logic [3:0] S_SIFT  = 4'd4;
    localparam logic [3:0] S_SIFTC = 4'd5;
    localparam logic [3:0] S_SHR   = 4'd6;
    localparam logic [3:0] S_SHW   = 4'd7;
    localparam logic [3:0] S_REPI  = 4'd8;
    localparam logic [3:0] S_REPL  = 4'd9;
    localparam logic [3:0] S_REPLC = 4'd10;
    localparam logic [3:0] S_REPRC = 4'd11;
    localparam logic [3:0] S_SW1   = 4'd12;
    localparam logic [3:0] S_SW2   = 4'd13;
    localparam logic [3:0] S_TOP   = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i, n_i;
    logic [AW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_j, n_j;
    logic          r_found, n_found;
    logic          r_swap, n_swap;
    logic [1:0]    r_func, n_func;
    logic [1:0]    r_status, n_status;
    logic [31:0]   r_value, n_value;
    logic [31:0]   r_a, n_a;
    logic [31:0]   r_b, n_b;
    logic          r_strobe, n_strobe;
    t_res          r_res, n_res;

    logic          we;
    logic [AW-1:0] waddr, raddr, parent;
    logic [31:0]   wdata, rdata;
    logic [LW-1:0] lidx, ridx, cnt_ext;

    mhp_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign parent  = AW'((r_cur - 1'b1) >> 1);
    assign lidx    = LW'({r_i, 1'b1});
    assign ridx    = lidx + 1'b1;
    assign cnt_ext = LW'(r_count);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_i      = r_i;
        n_cur    = r_cur;
        n_pos    = r_pos;
        n_j      = r_j;
        n_found  = r_found;
        n_swap   = r_swap;
        n_func   = r_func;
        n_status = r_status;
        n_value  = r_value;
        n_a      = r_a;
        n_b      = r_b;
        n_strobe = 1'b0;
        n_res    = r_res;
        we       = 1'b0;
        waddr    = r_cur;
        wdata    = r_value;
        raddr    = r_i[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_func   = i_req.func;
                    n_value  = i_req.value;
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    n_i      = '0;
                    n_state  = (r_count == '0) ? S_DISP : S_SCAN;
                end
            end
            S_SCAN: n_state = S_SCANC;
            S_SCANC: begin
                if (rdata == r_value) begin
                    n_found = 1'b1;
                    n_pos   = r_i[AW-1:0];
                    n_state = S_DISP;
                end else if (r_i + 1'b1 == r_count) begin
                    n_state = S_DISP;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_DISP: begin
                n_state = S_TOP;
                if (r_func == FUNC_INSERT) begin
                    if (r_count == CW'(DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_cur   = r_count[AW-1:0];
                        n_count = r_count + 1'b1;
                        n_state = S_SIFT;
                    end
                end else if (r_func == FUNC_REMOVE) begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else if (!r_found) begin
                        n_status = ST_NOT_FOUND;
                    end else begin
                        n_i     = CW'(r_pos);
                        n_state = S_SHR;
                    end
                end
            end
            S_SIFT: begin
                raddr = parent;
                if (r_cur == '0) begin
                    we      = 1'b1;
                    n_state = S_TOP;
                end else begin
                    n_state = S_SIFTC;
                end
            end
            S_SIFTC: begin
                we = 1'b1;
                if ($signed(r_value) > $signed(rdata)) begin
                    wdata   = rdata;
                    n_cur   = parent;
                    n_state = S_SIFT;
                end else begin
                    n_state = S_TOP;
                end
            end
            S_SHR: begin
                raddr = AW'(r_i + 1'b1);
                if (r_i + 1'b1 < r_count) begin
                    n_state = S_SHW;
                end else begin
                    n_count = r_count - 1'b1;
                    n_i     = '0;
                    n_swap  = 1'b0;
                    n_state = S_REPI;
                end
            end
            S_SHW: begin
                we      = 1'b1;
                waddr   = r_i[AW-1:0];
                wdata   = rdata;
                n_i     = r_i + 1'b1;
                n_state = S_SHR;
            end
            S_REPI: begin
                if (r_i >= r_count) begin
                    // pass done: another one only if this one swapped
                    n_i     = '0;
                    n_swap  = 1'b0;
                    n_state = r_swap ? S_REPI : S_TOP;
                end else begin
                    n_state = S_REPL;
                end
            end
            S_REPL: begin
                n_a   = rdata;
                raddr = lidx[AW-1:0];
                if (lidx < cnt_ext) begin
                    n_state = S_REPLC;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_REPI;
                end
            end
            S_REPLC: begin
                raddr = ridx[AW-1:0];
                if ($signed(rdata) > $signed(r_a)) begin
                    n_b     = rdata;
                    n_j     = lidx[AW-1:0];
                    n_state = S_SW1;
                end else if (ridx < cnt_ext) begin
                    n_state = S_REPRC;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_REPI;
                end
            end
            S_REPRC: begin
                if ($signed(rdata) > $signed(r_a)) begin
                    n_b     = rdata;
                    n_j     = ridx[AW-1:0];
                    n_state = S_SW1;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_REPI;
                end
            end
            S_SW1: begin
                we      = 1'b1;
                waddr   = r_i[AW-1:0];
                wdata   = r_b;
                n_state = S_SW2;
            end
            S_SW2: begin
                we      = 1'b1;
                waddr   = r_j;
                wdata   = r_a;
                n_swap  = 1'b1;
                n_i     = r_i + 1'b1;
                n_state = S_REPI;
            end
            S_TOP: begin
                raddr   = '0;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_strobe        = 1'b1;
                n_res.status    = r_status;
                n_res.found     = r_found;
                n_res.count     = 7'(r_count);
                n_res.top_value = (r_count != '0) ? rdata : '0;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_i      <= n_i;
        r_cur    <= n_cur;
        r_pos    <= n_pos;
        r_j      <= n_j;
        r_found  <= n_found;
        r_swap   <= n_swap;
        r_func   <= n_func;
        r_status <= n_status;
        r_value  <= n_value;
        r_a      <= n_a;
        r_b      <= n_b;
        r_res    <= n_res;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

[hdl/mhp_check.sv]
// port-level checks for the max-heap block, bound to the top level
// depends on mhp_pkg
module mhp_check
    import mhp_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input t_req i_req,
    input logic o_busy,
    input logic o_strobe,
    input t_res o_result
);

    // every request passes through S_DISP, S_TOP and S_OUT, so strobes never touch
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("back-to-back result strobes");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("request accepted but not busy");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.count == 7'd0 && DEPTH < 128) |-> o_result.top_value == 0)
        else $error("empty heap with non-zero root");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_EMPTY) |-> (o_result.count == 7'd0 && !o_result.found))
        else $error("empty status with entries present");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_FULL) |-> o_result.count == 7'(DEPTH))
        else $error("full status with room left");

endmodule

bind max_heap_insert_remove_find mhp_check #(.DEPTH(DEPTH)) u_mhp_check (.*);

[bench/max_heap_insert_remove_find_test.sv]
// self-checking bench for the max-heap block: directed then random requests
// depends on mhp_pkg and max_heap_insert_remove_find
module max_heap_insert_remove_find_test;
    import mhp_pkg::*;

    localparam int DEPTH = 64;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_strobe;
    t_res o_result;

    max_heap_insert_remove_find #(.DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_req(i_req),
        .o_busy(o_busy), .o_strobe(o_strobe), .o_result(o_result)
    );

    // predictor state
    logic signed [31:0] heap_mirror [DEPTH];
    int unsigned mirror_count;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   errors;
    int   results_seen;
    int   n_insert, n_remove, n_find, n_full, n_empty, n_absent;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("timeout at %0t", $time);
        $display("status: fail");
        $finish;
    end

    function automatic void swap_mirror(int unsigned a, int unsigned b);
        logic signed [31:0] t;
        t = heap_mirror[a];
        heap_mirror[a] = heap_mirror[b];
        heap_mirror[b] = t;
    endfunction

    function automatic t_res heap_predict(t_req rq);
        t_res r;
        int unsigned pos;
        int unsigned cur;
        int unsigned par;
        int unsigned lc;
        int unsigned rc;
        logic present;
        logic swapped;
        present = 1'b0;
        pos = 0;
        r.status = ST_OK;
        for (int unsigned k = 0; k < mirror_count; k++) begin
            if (!present && heap_mirror[k] == rq.value) begin
                present = 1'b1;
                pos = k;
            end
        end
        if (rq.func == FUNC_INSERT) begin
            n_insert++;
            if (mirror_count >= DEPTH) begin
                r.status = ST_FULL;
                n_full++;
            end else begin
                heap_mirror[mirror_count] = rq.value;
                mirror_count++;
                cur = mirror_count - 1;
                while (cur > 0) begin
                    par = (cur - 1) / 2;
                    if (!(heap_mirror[cur] > heap_mirror[par])) break;
                    swap_mirror(cur, par);
                    cur = par;
                end
            end
        end else if (rq.func == FUNC_REMOVE) begin
            n_remove++;
            if (mirror_count == 0) begin
                r.status = ST_EMPTY;
                n_empty++;
            end else if (!present) begin
                r.status = ST_NOT_FOUND;
                n_absent++;
            end else begin
                for (int unsigned k = pos; k + 1 < mirror_count; k++)
                    heap_mirror[k] = heap_mirror[k + 1];
                mirror_count--;
                do begin
                    swapped = 1'b0;
                    for (int unsigned k = 0; k < mirror_count; k++) begin
                        lc = 2 * k + 1;
                        rc = 2 * k + 2;
                        if (lc < mirror_count && heap_mirror[lc] > heap_mirror[k]) begin
                            swap_mirror(k, lc);
                            swapped = 1'b1;
                        end else if (rc < mirror_count && heap_mirror[rc] > heap_mirror[k]) begin
                            swap_mirror(k, rc);
                            swapped = 1'b1;
                        end
                    end
                end while (swapped);
            end
        end else begin
            n_find++;
        end
        r.found = present;
        r.count = mirror_count[6:0];
        r.top_value = (mirror_count > 0) ? heap_mirror[0] : 32'sd0;
        return r;
    endfunction

    function automatic t_req make_req(logic [1:0] f, logic signed [31:0] v);
        t_req rq;
        rq.func = f;
        rq.value = v;
        return rq;
    endfunction

    // small pool so removes and finds hit stored values often
    function automatic logic signed [31:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return $signed($urandom_range(0, 40)) - 32'sd20;
        if (sel == 6) return 32'sh7fffffff;
        if (sel == 7) return 32'sh80000000;
        return $signed($urandom());
    endfunction

    // driver
    int  gap_left;
    int  drain_at;
    int  sent;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_req <= '0;
            gap_left <= 0;
            sent <= 0;
        end else if (i_start && !o_busy) begin
            // request taken at this edge
            expected_results.push_back(heap_predict(i_req));
            sent <= sent + 1;
            void'(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && $urandom_range(0, 3) == 0 && sent + 1 != drain_at) begin
                i_req <= pending_reqs[0];
            end else begin
                i_start <= 1'b0;
                gap_left <= $urandom_range(0, 3);
            end
        end else if (!i_start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_reqs.size() > 0
                         && !(sent == drain_at && expected_results.size() > 0)) begin
                i_req <= pending_reqs[0];
                i_start <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual %p", $time, o_result);
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status) begin
                    errors++;
                    $display("%0t status: expected %0d actual %0d", $time,
                             want.status, o_result.status);
                end
                if (o_result.found !== want.found) begin
                    errors++;
                    $display("%0t found: expected %0d actual %0d", $time,
                             want.found, o_result.found);
                end
                if (o_result.count !== want.count) begin
                    errors++;
                    $display("%0t count: expected %0d actual %0d", $time,
                             want.count, o_result.count);
                end
                if (o_result.top_value !== want.top_value) begin
                    errors++;
                    $display("%0t top_value: expected %0d actual %0d", $time,
                             want.top_value, o_result.top_value);
                end
            end
        end
    end

    initial begin
        int unsigned r;
        int wait_cycles;
        i_rst_n = 1'b0;
        // directed part
        pending_reqs.push_back(make_req(FUNC_REMOVE, 32'sd5));
        pending_reqs.push_back(make_req(FUNC_FIND, 32'sd5));
        pending_reqs.push_back(make_req(FUNC_INSERT, 32'sh80000000));
        pending_reqs.push_back(make_req(FUNC_INSERT, 32'sh7fffffff));
        pending_reqs.push_back(make_req(FUNC_INSERT, -32'sd1));
        pending_reqs.push_back(make_req(FUNC_INSERT, 32'sd0));
        pending_reqs.push_back(make_req(FUNC_INSERT, 32'sd0));
        pending_reqs.push_back(make_req(FUNC_FIND, 32'sh7fffffff));
        pending_reqs.push_back(make_req(FUNC_SPARE, 32'sh80000000));
        pending_reqs.push_back(make_req(FUNC_REMOVE, 32'sd77));
        pending_reqs.push_back(make_req(FUNC_REMOVE, 32'sh7fffffff));
        pending_reqs.push_back(make_req(FUNC_REMOVE, 32'sd0));
        pending_reqs.push_back(make_req(FUNC_REMOVE, 32'sh80000000));
        pending_reqs.push_back(make_req(FUNC_REMOVE, -32'sd1));
        pending_reqs.push_back(make_req(FUNC_REMOVE, 32'sd0));
        pending_reqs.push_back(make_req(FUNC_REMOVE, 32'sd0));
        // fill past full to hit the refused insert
        for (int k = 0; k < DEPTH + 2; k++)
            pending_reqs.push_back(make_req(FUNC_INSERT, $signed($urandom())));
        drain_at = pending_reqs.size();
        // random part: phases drifting between filling and draining
        for (int k = 0; k < 668; k++) begin
            r = $urandom_range(0, 99);
            if ((k / 150) % 2 == 0)
                pending_reqs.push_back(make_req(r < 40 ? FUNC_INSERT : r < 70 ? FUNC_REMOVE
                                       : r < 95 ? FUNC_FIND : FUNC_SPARE, pick_value()));
            else
                pending_reqs.push_back(make_req(r < 20 ? FUNC_INSERT : r < 75 ? FUNC_REMOVE
                                       : r < 95 ? FUNC_FIND : FUNC_SPARE, pick_value()));
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !i_start);
        wait_cycles = 0;
        while (expected_results.size() > 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        $display("covered %0d inserts (%0d refused full), %0d removes (%0d empty, %0d absent),",
                 n_insert, n_full, n_remove, n_empty, n_absent);
        $display("%0d finds; %0d results checked, %0d mismatches", n_find, results_seen, errors);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[max_heap_insert_remove_find.f]
hdl/mhp_pkg.sv
hdl/mhp_ram.sv
hdl/max_heap_insert_remove_find.sv
hdl/mhp_check.sv
bench/max_heap_insert_remove_find_test.sv
